### src/ffrt_pkg.sv
// shared types and constants for the frame fragment reassembly table
package ffrt_pkg;

   localparam int unsigned SLOTS_DEFAULT = 20;
   localparam logic [15:0] STRIDE_RESET  = 16'd50000;

   typedef struct packed {
      logic [15:0] frame_stamp;
      logic [7:0]  section_index;
      logic [7:0]  section_total;
      logic [15:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [4:0]  slot;
      logic [23:0] write_offset;
      logic        new_frame;
      logic        evicted_incomplete;
      logic [15:0] evicted_stamp;
      logic        frame_complete;
      logic [23:0] frame_size;
      logic [31:0] frames_received;
      logic [31:0] frames_dropped;
   } rsp_type;

   // lookup token handed from cell to cell
   typedef struct packed {
      logic        valid;
      logic        found;
      logic [15:0] stamp;
      logic [15:0] plen;
      logic        complete;
      logic [23:0] size;
      logic [15:0] old_stamp;
      logic        old_live;
   } token_type;

   // write into the slot under the claim pointer
   typedef struct packed {
      logic        en;
      logic [15:0] stamp;
      logic [7:0]  remaining;
      logic [23:0] bytes;
   } claim_type;

endpackage

### src/ffrt_cell.sv
// one slot of the table: holds its entry and forwards the lookup token
module ffrt_cell #(
   parameter int unsigned IDX_W   = 5,
   parameter int unsigned CELL_ID = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [IDX_W-1:0]      claim_ptr,
   input  ffrt_pkg::claim_type   claim,
   input  ffrt_pkg::token_type   tok_in,
   input  logic [IDX_W-1:0]      slot_in,
   output ffrt_pkg::token_type   tok_out,
   output logic [IDX_W-1:0]      slot_out
);
   import ffrt_pkg::*;

   logic [15:0]    stamp_ff;
   logic [7:0]     remaining_ff;
   logic [23:0]    bytes_ff;
   token_type      tok_ff;
   token_type      tok_in_next;
   logic [IDX_W-1:0] slot_ff;
   logic [IDX_W-1:0] slot_in_next;

   logic        match;
   logic        mine;
   logic [7:0]  rem_dec;
   logic [23:0] bytes_sum;

   assign match     = tok_in.valid && !tok_in.found && (stamp_ff == tok_in.stamp);
   assign mine      = (claim_ptr == IDX_W'(CELL_ID));
   assign rem_dec   = remaining_ff - 8'd1;
   assign bytes_sum = bytes_ff + {8'd0, tok_in.plen};

   always_comb begin
      tok_in_next  = tok_in;
      slot_in_next = slot_in;
      if (match) begin
         tok_in_next.found    = 1'b1;
         tok_in_next.complete = (rem_dec == 8'd0);
         tok_in_next.size     = bytes_sum;
         slot_in_next         = IDX_W'(CELL_ID);
      end
      // snapshot of the entry a miss would take over
      if (mine) begin
         tok_in_next.old_stamp = stamp_ff;
         tok_in_next.old_live  = (remaining_ff != 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff     <= '0;
         remaining_ff <= '0;
         bytes_ff     <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         if (claim.en && mine) begin
            stamp_ff     <= claim.stamp;
            remaining_ff <= claim.remaining;
            bytes_ff     <= claim.bytes;
         end else if (match) begin
            remaining_ff <= rem_dec;
            bytes_ff     <= bytes_sum;
         end
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.found     <= tok_in_next.found;
      tok_ff.stamp     <= tok_in_next.stamp;
      tok_ff.plen      <= tok_in_next.plen;
      tok_ff.complete  <= tok_in_next.complete;
      tok_ff.size      <= tok_in_next.size;
      tok_ff.old_stamp <= tok_in_next.old_stamp;
      tok_ff.old_live  <= tok_in_next.old_live;
      slot_ff          <= slot_in_next;
   end

   assign tok_out  = tok_ff;
   assign slot_out = slot_ff;

endmodule

### src/frame_fragment_reassembly_table.sv
// top level of the frame fragment reassembly table
//
//  channel  | ports                         | direction | transfer when
//  ---------+-------------------------------+-----------+---------------------------
//  request  | start, busy, req_data         | in        | start high, busy low
//  response | rsp_valid, rsp_data           | out       | every cycle rsp_valid high
//  csr      | csr_valid, csr_ready, csr_data| in        | csr_valid and csr_ready high
//
// from accept to response the lookup token walks the row of slot cells one cell a cycle,
// then the response register settles the claim or hit
// busy is high from the accept edge until the response is raised; a new header can be
// accepted in the same cycle that the response is shown
// reset clears all slots, the claim pointer, the counters and restores the stride
// the response is a single-cycle strobe and cannot be stalled by the receiver
module frame_fragment_reassembly_table #(
   parameter int unsigned SLOTS = ffrt_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffrt_pkg::req_type req_data,
   output logic              rsp_valid,
   output ffrt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);
   import ffrt_pkg::*;

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // control and payload registers
   logic             busy_ff;
   req_type          req_ff;
   logic [23:0]      offset_ff;
   logic [15:0]      stride_ff;
   logic [IDX_W-1:0] claim_ptr_ff;
   logic [IDX_W-1:0] claim_ptr_in;
   logic [31:0]      received_ff;
   logic [31:0]      dropped_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   // token chain between the cells
   token_type        tok   [0:SLOTS];
   logic [IDX_W-1:0] slot_c[0:SLOTS];

   claim_type   claim;
   logic        accept;
   logic        done;
   logic        miss;
   logic        evict;
   logic [7:0]  new_remaining;
   logic [23:0] product;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;
   // stride is only changed between headers, never alongside a header transfer
   assign csr_ready = !busy_ff && !start;

   // header enters the first cell on the accept edge
   always_comb begin
      tok[0].valid     = accept;
      tok[0].found     = 1'b0;
      tok[0].stamp     = req_data.frame_stamp;
      tok[0].plen      = req_data.payload_length;
      tok[0].complete  = 1'b0;
      tok[0].size      = '0;
      tok[0].old_stamp = '0;
      tok[0].old_live  = 1'b0;
      slot_c[0]        = '0;
   end

   genvar gi;
   generate
      for (gi = 0; gi < SLOTS; gi++) begin : g_cell
         ffrt_cell #(
            .IDX_W   (IDX_W),
            .CELL_ID (gi)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .claim_ptr (claim_ptr_ff),
            .claim     (claim),
            .tok_in    (tok[gi]),
            .slot_in   (slot_c[gi]),
            .tok_out   (tok[gi+1]),
            .slot_out  (slot_c[gi+1])
         );
      end
   endgenerate

   // token leaving the last cell finishes the lookup
   assign done  = tok[SLOTS].valid;
   assign miss  = done && !tok[SLOTS].found;
   assign evict = miss && (tok[SLOTS].old_stamp != 16'd0) && tok[SLOTS].old_live;

   assign new_remaining = req_ff.section_total - 8'd1;

   // on a miss the slot under the claim pointer is taken over
   always_comb begin
      claim.en        = miss;
      claim.stamp     = req_ff.frame_stamp;
      claim.remaining = new_remaining;
      claim.bytes     = {8'd0, req_ff.payload_length};
   end

   assign claim_ptr_in = (claim_ptr_ff == IDX_W'(SLOTS - 1)) ? '0 : claim_ptr_ff + 1'b1;

   // 8 x 16 product fits the offset field exactly
   assign product = {16'd0, req_data.section_index} * {8'd0, stride_ff};

   always_comb begin
      rsp_in.write_offset       = offset_ff;
      rsp_in.new_frame          = miss;
      rsp_in.evicted_incomplete = evict;
      rsp_in.evicted_stamp      = evict ? tok[SLOTS].old_stamp : 16'd0;
      rsp_in.frames_received    = received_ff + {31'd0, miss};
      rsp_in.frames_dropped     = dropped_ff + {31'd0, evict};
      if (tok[SLOTS].found) begin
         rsp_in.slot           = 5'(slot_c[SLOTS]);
         rsp_in.frame_complete = tok[SLOTS].complete;
         rsp_in.frame_size     = tok[SLOTS].size;
      end else begin
         rsp_in.slot           = 5'(claim_ptr_ff);
         rsp_in.frame_complete = (new_remaining == 8'd0);
         rsp_in.frame_size     = {8'd0, req_ff.payload_length};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stride_ff    <= STRIDE_RESET;
         claim_ptr_ff <= '0;
         received_ff  <= '0;
         dropped_ff   <= '0;
      end else begin
         rsp_valid_ff <= done;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            stride_ff <= csr_data;
         end
         if (done) begin
            received_ff <= rsp_in.frames_received;
            dropped_ff  <= rsp_in.frames_dropped;
         end
         if (miss) begin
            claim_ptr_ff <= claim_ptr_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff    <= req_data;
         offset_ff <= product;
      end
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### src/ffrt_checker.sv
// port-level checks for the reassembly table and their bind
module ffrt_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input ffrt_pkg::rsp_type rsp_data,
   input logic              rsp_valid
);
   import ffrt_pkg::*;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after header transfer");

   a_rsp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("response without a header in flight");

   a_busy_fall_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("lookup finished without a response");

   a_evict_on_claim: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.evicted_incomplete) |->
         (rsp_data.new_frame && (rsp_data.evicted_stamp != 16'd0)))
      else $error("drop reported without a claim of a live slot");

   a_no_stamp_without_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.evicted_incomplete) |-> (rsp_data.evicted_stamp == 16'd0))
      else $error("dropped stamp shown without a drop");

endmodule

bind frame_fragment_reassembly_table ffrt_checker u_ffrt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);

### tb/frame_fragment_reassembly_table_tb.sv
// testbench for the frame fragment reassembly table: directed headers, slot wrap and random traffic
module frame_fragment_reassembly_table_tb;
   import ffrt_pkg::*;

   localparam int unsigned N_SLOTS = SLOTS_DEFAULT;
   // accept to response walks the token through every slot cell, keep a margin on top
   localparam int unsigned SETTLE_CYCLES = N_SLOTS + 8;
   localparam int unsigned OPEN_FRAMES = 6;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   frame_fragment_reassembly_table #(
      .SLOTS(N_SLOTS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 4 time unit period
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // own copy of the slot table, the claim pointer, the counters and the stride
   logic [15:0] tbl_stamp [N_SLOTS];
   logic [7:0]  tbl_left  [N_SLOTS];
   logic [23:0] tbl_bytes [N_SLOTS];
   int unsigned next_claim;
   logic [31:0] new_count;
   logic [31:0] drop_count;
   logic [15:0] stride_now;

   // placements predicted for accepted headers, oldest first
   rsp_type placement_q [$];
   int unsigned fail_count;

   // sender side bookkeeping
   bit start_on;        // start as it stands after the current step
   int unsigned burst_left;  // headers left in a stretch without idling

   // random traffic keeps a few frames open at once and interleaves them
   bit          of_live  [OPEN_FRAMES];
   logic [15:0] of_stamp [OPEN_FRAMES];
   logic [7:0]  of_total [OPEN_FRAMES];
   logic [7:0]  of_next  [OPEN_FRAMES];
   int unsigned of_sends [OPEN_FRAMES];

   task automatic clear_table();
      for (int i = 0; i < N_SLOTS; i++) begin
         tbl_stamp[i] = '0;
         tbl_left[i]  = '0;
         tbl_bytes[i] = '0;
      end
      next_claim = 0;
      new_count  = '0;
      drop_count = '0;
      stride_now = STRIDE_RESET;
   endtask

   // lowest matching stamp wins, otherwise the slot under the claim pointer is taken over
   function automatic rsp_type predict_placement(input req_type r);
      rsp_type     p;
      int unsigned s;
      bit          hit;
      p   = '0;
      hit = 1'b0;
      s   = 0;
      for (int i = 0; i < N_SLOTS; i++) begin
         if (!hit && tbl_stamp[i] == r.frame_stamp) begin
            hit = 1'b1;
            s   = i;
         end
      end
      if (hit) begin
         tbl_left[s]  = tbl_left[s] - 8'd1;
         tbl_bytes[s] = tbl_bytes[s] + 24'(r.payload_length);
      end else begin
         s           = next_claim;
         p.new_frame = 1'b1;
         new_count   = new_count + 32'd1;
         // only a live frame with sections still missing counts as dropped
         if (tbl_stamp[s] != '0 && tbl_left[s] != '0) begin
            p.evicted_incomplete = 1'b1;
            p.evicted_stamp      = tbl_stamp[s];
            drop_count           = drop_count + 32'd1;
         end
         tbl_stamp[s] = r.frame_stamp;
         tbl_left[s]  = r.section_total - 8'd1;
         tbl_bytes[s] = 24'(r.payload_length);
         next_claim   = (s + 1) % N_SLOTS;
      end
      p.slot            = 5'(s);
      p.write_offset    = 24'(r.section_index) * 24'(stride_now);
      p.frame_complete  = (tbl_left[s] == '0);
      p.frame_size      = tbl_bytes[s];
      p.frames_received = new_count;
      p.frames_dropped  = drop_count;
      return p;
   endfunction

   function automatic req_type make_hdr(input logic [15:0] stamp, input logic [7:0] idx,
                                        input logic [7:0] total, input logic [15:0] len);
      req_type r;
      r.frame_stamp    = stamp;
      r.section_index  = idx;
      r.section_total  = total;
      r.payload_length = len;
      return r;
   endfunction

   // lower start at the current edge if nothing follows right away
   task automatic stop_requests();
      if (start_on) begin
         start    <= 1'b0;
         start_on  = 1'b0;
      end
   endtask

   // called at a rising edge, returns at the edge where the header transfer took place
   // start is left high there so a back-to-back header needs no second assignment
   task automatic send_hdr(input req_type r);
      int unsigned gap;
      if (burst_left > 0) begin
         gap        = 0;
         burst_left = burst_left - 1;
      end else begin
         gap = $urandom_range(0, 17);
         if ($urandom_range(0, 39) == 0) begin
            burst_left = $urandom_range(10, 40);
         end
      end
      if (gap > 0) begin
         stop_requests();
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      if (!start_on) begin
         start    <= 1'b1;
         start_on  = 1'b1;
      end
      do begin
         @(posedge clock);
      end while (busy);
      placement_q.push_back(predict_placement(r));
   endtask

   // sender holds off until every predicted placement has come back
   task automatic wait_drained();
      stop_requests();
      while (placement_q.size() != 0) begin
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   // stride is only changed with the table idle
   task automatic write_stride(input logic [15:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid  <= 1'b0;
      stride_now  = value;
   endtask

   // stamp zero on an empty slot, zero and one section counts, surplus fragments, field extremes
   task automatic test_special_headers();
      send_hdr(make_hdr(16'd0, 8'd0, 8'd3, 16'd100));       // stamp zero hits empty slot 0
      send_hdr(make_hdr(16'd1, 8'd255, 8'd0, 16'hffff));    // claims slot 0 silently, 255 left
      send_hdr(make_hdr(16'd1, 8'd1, 8'd0, 16'hffff));
      send_hdr(make_hdr(16'hffff, 8'd0, 8'd1, 16'd0));      // single section frame
      send_hdr(make_hdr(16'hffff, 8'd2, 8'd1, 16'd7));      // surplus fragment wraps to 255
      send_hdr(make_hdr(16'd2, 8'd0, 8'd2, 16'h5a5a));
      send_hdr(make_hdr(16'd2, 8'd1, 8'd2, 16'ha5a5));      // completes slot 2
   endtask

   // fill the rest of the table so the claim pointer wraps onto live and complete slots
   task automatic test_claim_eviction();
      for (int s = 3; s < N_SLOTS; s++) begin
         send_hdr(make_hdr(16'(s), 8'd0, 8'd2, 16'(s * 1000)));
      end
      send_hdr(make_hdr(16'd20, 8'd0, 8'd3, 16'd1));    // drops stamp 1
      send_hdr(make_hdr(16'd21, 8'd0, 8'd3, 16'd2));    // drops the wrapped surplus frame
      send_hdr(make_hdr(16'd22, 8'd0, 8'd3, 16'd3));    // complete slot taken silently
   endtask

   function automatic logic [15:0] pick_stamp();
      int unsigned k;
      k = $urandom_range(0, 15);
      if (k == 0) return 16'd0;
      if (k < 3) return 16'($urandom_range(1, 8));
      return 16'($urandom_range(1, 65535));
   endfunction

   task automatic open_frame(input int unsigned f);
      of_live[f]  = 1'b1;
      of_stamp[f] = pick_stamp();
      of_next[f]  = '0;
      if ($urandom_range(0, 7) == 0) begin
         of_total[f] = 8'($urandom);
      end else begin
         of_total[f] = 8'($urandom_range(1, 6));
      end
      // long and zero-count frames stop early and linger as incomplete
      if (of_total[f] == 0 || of_total[f] > 8) begin
         of_sends[f] = $urandom_range(1, 8);
      end else begin
         of_sends[f] = of_total[f];
      end
   endtask

   // mostly interleaved well-formed frames, the rest noise and broken frames
   task automatic run_traffic(input int unsigned n_items);
      int unsigned f;
      req_type     r;
      for (int i = 0; i < OPEN_FRAMES; i++) begin
         of_live[i] = 1'b0;
      end
      for (int k = 0; k < n_items; k++) begin
         if ($urandom_range(0, 9) < 7) begin
            f = $urandom_range(0, OPEN_FRAMES - 1);
            if (!of_live[f]) begin
               open_frame(f);
            end
            r = make_hdr(of_stamp[f], of_next[f], of_total[f], 16'($urandom));
            if ($urandom_range(0, 19) == 0) begin
               r.section_index = 8'($urandom);
            end
            if ($urandom_range(0, 19) == 0) begin
               r.payload_length = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hffff;
            end
            of_next[f]  = of_next[f] + 8'd1;
            of_sends[f] = of_sends[f] - 1;
            // now and then a frame loses its remaining fragments
            if (of_sends[f] == 0 || $urandom_range(0, 29) == 0) begin
               of_live[f] = 1'b0;
            end
         end else begin
            r = req_type'(48'({$urandom, $urandom}));
            if ($urandom_range(0, 3) == 0) begin
               r.frame_stamp = '0;
            end
         end
         send_hdr(r);
         if (k % 97 == 96) begin
            wait_drained();
         end
      end
   endtask

   // random traffic under stride extremes, zero stride, a random stride and the reset value
   task automatic test_stride_phases();
      logic [15:0] strides [5];
      strides[0] = 16'hffff;
      strides[1] = 16'd1;
      strides[2] = 16'd0;
      strides[3] = 16'($urandom_range(2, 65534));
      strides[4] = STRIDE_RESET;
      for (int p = 0; p < 5; p++) begin
         write_stride(strides[p]);
         run_traffic(260);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch expected %0h actual %0h", $time, name, want, got);
         fail_count = fail_count + 1;
      end
   endtask

   // every response strobe is one transfer, compared with the oldest prediction
   always @(posedge clock) begin : rsp_compare
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (placement_q.size() == 0) begin
            $display("%0t: response with nothing pending expected none actual %0h",
                     $time, rsp_data);
            fail_count = fail_count + 1;
         end else begin
            want = placement_q.pop_front();
            check_field("slot", 32'(want.slot), 32'(rsp_data.slot));
            check_field("write_offset", 32'(want.write_offset), 32'(rsp_data.write_offset));
            check_field("new_frame", 32'(want.new_frame), 32'(rsp_data.new_frame));
            check_field("evicted_incomplete", 32'(want.evicted_incomplete),
                        32'(rsp_data.evicted_incomplete));
            check_field("evicted_stamp", 32'(want.evicted_stamp), 32'(rsp_data.evicted_stamp));
            check_field("frame_complete", 32'(want.frame_complete),
                        32'(rsp_data.frame_complete));
            check_field("frame_size", 32'(want.frame_size), 32'(rsp_data.frame_size));
            check_field("frames_received", want.frames_received, rsp_data.frames_received);
            check_field("frames_dropped", want.frames_dropped, rsp_data.frames_dropped);
         end
      end
   end

   initial begin : stimulus
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      start_on   = 1'b0;
      burst_left = 0;
      fail_count = 0;
      clear_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_special_headers();
      test_claim_eviction();
      wait_drained();
      test_stride_phases();

      // drain and let the lookup row settle before the verdict
      stop_requests();
      while (placement_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

### frame_fragment_reassembly_table.f
src/ffrt_pkg.sv
src/ffrt_cell.sv
src/frame_fragment_reassembly_table.sv
src/ffrt_checker.sv
tb/frame_fragment_reassembly_table_tb.sv
